// ===== rtl/mouse_gesture_stroke_recognizer_macros.svh =====
// assertion macros for the mouse gesture stroke recognizer
// used by rtl modules that carry concurrent assertions
`ifndef MOUSE_GESTURE_STROKE_RECOGNIZER_MACROS_SVH
`define MOUSE_GESTURE_STROKE_RECOGNIZER_MACROS_SVH

// condition holds at every edge out of reset
`define MGSR_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle
`define MGSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the next cycle
`define MGSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mgsr_pkg.sv =====
// shared types and constants for the mouse gesture stroke recognizer
// no dependencies
`default_nettype none

package mgsr_pkg;

    // event modes
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_MOVE   = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;
    localparam logic [1:0] MODE_CANCEL = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STROKE_TOL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAIN_EN       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_EN         = 2'd3;

    localparam logic [7:0] CFG_RST_THRESHOLD = 8'd5;
    localparam logic [7:0] CFG_RST_TOL       = 8'd20;

    // directions
    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    localparam logic [2:0] SECTOR_NONE = 3'd4;

    // magnitudes at or above 2**SQ_BITS always count as a stroke
    localparam int SQ_BITS = 8;

    // queue between front and execute
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    typedef struct packed {
        logic is_start;
        logic is_move;
        logic is_finish;
        logic is_cancel;
        logic start_ok;
        logic alt;
    } t_op;

    typedef struct packed {
        logic [7:0]  move_threshold;
        logic [15:0] tol_sq;
        logic        plain_en;
        logic        alt_en;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/mgsr_front.sv =====
// input side: accepts pointer events, decodes the mode and checks start enables
// depends on mgsr_pkg
`default_nettype none

module mgsr_front #(
    parameter int COORD_BITS = 16,
    parameter int IN_DATA_W  = 32,
    parameter int ITEM_W     = 38
) (
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  wire logic [2:0]            i_s_axis_tuser,
    input  wire mgsr_pkg::t_cfg        i_cfg,
    input  wire logic                  i_q_full,
    output logic                       o_push,
    output logic [ITEM_W-1:0]          o_push_data
);

    mgsr_pkg::t_op w_op;
    logic [1:0]    w_mode;
    logic          w_alt;

    assign w_mode = i_s_axis_tuser[1:0];
    assign w_alt  = i_s_axis_tuser[2];

    always_comb begin
        w_op          = '0;
        w_op.alt      = w_alt;
        w_op.start_ok = w_alt ? i_cfg.alt_en : i_cfg.plain_en;
        case (w_mode)
            mgsr_pkg::MODE_START:  w_op.is_start  = 1'b1;
            mgsr_pkg::MODE_MOVE:   w_op.is_move   = 1'b1;
            mgsr_pkg::MODE_FINISH: w_op.is_finish = 1'b1;
            mgsr_pkg::MODE_CANCEL: w_op.is_cancel = 1'b1;
            default:               w_op.is_cancel = 1'b1;
        endcase
    end

    assign o_s_axis_tready = i_rst_n && !i_q_full;
    assign o_push          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_push_data     = {w_op, i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS],
                              i_s_axis_tdata[COORD_BITS-1:0]};

endmodule

`default_nettype wire

// ===== rtl/mgsr_fifo.sv =====
// two-entry queue between the front and the execute unit
// depends on mgsr_pkg
`default_nettype none

module mgsr_fifo #(
    parameter int ITEM_W = 38
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [ITEM_W-1:0] i_push_data,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output logic [ITEM_W-1:0]      o_head
);

    logic [ITEM_W-1:0]     r_mem [mgsr_pkg::QDEPTH];
    logic [mgsr_pkg::QAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [mgsr_pkg::QAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [mgsr_pkg::QAW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (mgsr_pkg::QAW+1)'(mgsr_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mgsr_exec.sv =====
// execute unit: gesture state, stroke math, direction store and result register
// depends on mgsr_pkg and mouse_gesture_stroke_recognizer_macros.svh
`default_nettype none
`include "mouse_gesture_stroke_recognizer_macros.svh"

module mgsr_exec #(
    parameter int MAX_DIRS   = 16,
    parameter int COORD_BITS = 16,
    parameter int ITEM_W     = 38
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mgsr_pkg::t_cfg    i_cfg,
    input  wire logic              i_q_empty,
    input  wire logic [ITEM_W-1:0] i_q_head,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_out_consumed,
    output logic                   o_out_has_dir,
    output logic [1:0]             o_out_dir,
    output logic [COORD_BITS-1:0]  o_out_x,
    output logic [COORD_BITS-1:0]  o_out_y,
    output logic                   o_out_last
);

    localparam int CNT_W = $clog2(MAX_DIRS + 1);
    localparam int AW    = $clog2(MAX_DIRS);
    localparam int CB    = COORD_BITS;

    localparam logic [2:0] S_POP  = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    mgsr_pkg::t_op     w_q_op;
    logic [CB-1:0]     w_q_x, w_q_y;

    logic [2:0]        r_state, n_state;
    mgsr_pkg::t_op     r_op, n_op;
    logic [CB-1:0]     r_x, n_x, r_y, n_y;
    logic              r_active, n_active;
    logic              r_rec, n_rec;
    logic              r_galt, n_galt;
    logic [CB-1:0]     r_ref_x, n_ref_x, r_ref_y, n_ref_y;
    logic [CB-1:0]     r_start_x, n_start_x, r_start_y, n_start_y;
    logic [2:0]        r_prev, n_prev;
    logic [1:0]        r_last_dir, n_last_dir;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_rd_idx, n_rd_idx;
    logic [1:0]        r_mem [MAX_DIRS];
    logic [1:0]        r_rd_data;

    // stroke pipeline
    logic [CB:0]       w_dx, w_dy;
    logic [CB-1:0]     r_ax, r_ay;
    logic              r_dx_neg, r_dy_neg;
    logic [16:0]       r_sq_sum;
    logic              r_big, r_below;
    logic [1:0]        r_sector;
    logic              w_counts;

    logic              r_out_valid, n_out_valid;
    logic              r_out_cons, n_out_cons;
    logic              r_out_hasd, n_out_hasd;
    logic [1:0]        r_out_dir, n_out_dir;
    logic [CB-1:0]     r_out_x, n_out_x, r_out_y, n_out_y;
    logic              r_out_last, n_out_last;

    logic              w_out_free;
    logic              w_emit;
    logic              w_wr;
    logic [CNT_W-1:0]  w_rd_next;

    assign w_q_op = i_q_head[ITEM_W-1:2*CB];
    assign w_q_y  = i_q_head[2*CB-1:CB];
    assign w_q_x  = i_q_head[CB-1:0];

    assign w_dx = {r_x[CB-1], r_x} - {r_ref_x[CB-1], r_ref_x};
    assign w_dy = {r_y[CB-1], r_y} - {r_ref_y[CB-1], r_ref_y};

    assign w_counts  = r_big || ({r_sq_sum, 2'b00} > {3'b000, i_cfg.tol_sq});
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_rd_next  = r_rd_idx + CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_x         = r_x;
        n_y         = r_y;
        n_active    = r_active;
        n_rec       = r_rec;
        n_galt      = r_galt;
        n_ref_x     = r_ref_x;
        n_ref_y     = r_ref_y;
        n_start_x   = r_start_x;
        n_start_y   = r_start_y;
        n_prev      = r_prev;
        n_last_dir  = r_last_dir;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_out_cons  = r_out_cons;
        n_out_hasd  = r_out_hasd;
        n_out_dir   = r_out_dir;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_last  = r_out_last;
        w_emit      = 1'b0;
        w_wr        = 1'b0;
        o_q_pop     = 1'b0;
        case (r_state)
            S_POP: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_op    = w_q_op;
                    n_x     = w_q_x;
                    n_y     = w_q_y;
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = S_SQ;
            end
            S_SQ: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                if (w_out_free) begin
                    w_emit     = 1'b1;
                    n_state    = S_POP;
                    n_out_cons = 1'b0;
                    n_out_hasd = 1'b0;
                    n_out_dir  = mgsr_pkg::DIR_RIGHT;
                    n_out_last = 1'b1;
                    if (r_op.is_start) begin
                        if (!r_active && r_op.start_ok) begin
                            n_active  = 1'b1;
                            n_rec     = 1'b0;
                            n_galt    = r_op.alt;
                            n_ref_x   = r_x;
                            n_ref_y   = r_y;
                            n_start_x = r_x;
                            n_start_y = r_y;
                            n_prev    = mgsr_pkg::SECTOR_NONE;
                            n_count   = '0;
                        end
                    end else if (r_op.is_move) begin
                        if (r_active && r_op.alt != r_galt) begin
                            n_active = 1'b0;
                        end else if (r_active && (r_rec || !r_below)) begin
                            n_rec      = 1'b1;
                            n_out_cons = 1'b1;
                            if (w_counts) begin
                                n_ref_x = r_x;
                                n_ref_y = r_y;
                                if (r_prev != {1'b0, r_sector}) begin
                                    n_prev = {1'b0, r_sector};
                                end else if (r_count == '0 || r_last_dir != r_sector) begin
                                    if (r_count < CNT_W'(MAX_DIRS)) begin
                                        w_wr       = 1'b1;
                                        n_count    = r_count + CNT_W'(1);
                                        n_last_dir = r_sector;
                                    end
                                end
                            end
                        end
                    end else if (r_op.is_finish) begin
                        if (r_active && r_op.alt == r_galt) begin
                            n_active = 1'b0;
                            if (r_count != '0) begin
                                w_emit   = 1'b0;
                                n_rd_idx = '0;
                                n_state  = S_RD;
                            end
                        end
                    end else begin
                        n_active = 1'b0;
                    end
                    n_out_x = n_start_x;
                    n_out_y = n_start_y;
                end
            end
            S_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    w_emit     = 1'b1;
                    n_out_cons = 1'b1;
                    n_out_hasd = 1'b1;
                    n_out_dir  = r_rd_data;
                    n_out_x    = r_start_x;
                    n_out_y    = r_start_y;
                    n_out_last = (w_rd_next == r_count);
                    if (w_rd_next == r_count) begin
                        n_state = S_POP;
                    end else begin
                        n_rd_idx = w_rd_next;
                        n_state  = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_POP;
            end
        endcase
        n_out_valid = w_emit || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_POP;
            r_active    <= 1'b0;
            r_rec       <= 1'b0;
            r_galt      <= 1'b0;
            r_ref_x     <= '0;
            r_ref_y     <= '0;
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_prev      <= mgsr_pkg::SECTOR_NONE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_rec       <= n_rec;
            r_galt      <= n_galt;
            r_ref_x     <= n_ref_x;
            r_ref_y     <= n_ref_y;
            r_start_x   <= n_start_x;
            r_start_y   <= n_start_y;
            r_prev      <= n_prev;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_x        <= n_x;
        r_y        <= n_y;
        r_last_dir <= n_last_dir;
        r_out_cons <= n_out_cons;
        r_out_hasd <= n_out_hasd;
        r_out_dir  <= n_out_dir;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_last <= n_out_last;
        // stroke pipeline: deltas, then squares and sector
        r_dx_neg   <= w_dx[CB];
        r_dy_neg   <= w_dy[CB];
        r_ax       <= w_dx[CB] ? CB'(-w_dx) : w_dx[CB-1:0];
        r_ay       <= w_dy[CB] ? CB'(-w_dy) : w_dy[CB-1:0];
        r_sq_sum   <= 17'(r_ax[mgsr_pkg::SQ_BITS-1:0] * r_ax[mgsr_pkg::SQ_BITS-1:0])
                    + 17'(r_ay[mgsr_pkg::SQ_BITS-1:0] * r_ay[mgsr_pkg::SQ_BITS-1:0]);
        r_big      <= ((r_ax >> mgsr_pkg::SQ_BITS) != '0) || ((r_ay >> mgsr_pkg::SQ_BITS) != '0);
        r_below    <= (r_ax < CB'(i_cfg.move_threshold)) && (r_ay < CB'(i_cfg.move_threshold));
        if (r_ax >= r_ay) begin
            r_sector <= r_dx_neg ? mgsr_pkg::DIR_LEFT : mgsr_pkg::DIR_RIGHT;
        end else begin
            r_sector <= r_dy_neg ? mgsr_pkg::DIR_UP : mgsr_pkg::DIR_DOWN;
        end
    end

    // direction store
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_count[AW-1:0]] <= r_sector;
        end
        r_rd_data <= r_mem[r_rd_idx[AW-1:0]];
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_consumed = r_out_cons;
    assign o_out_has_dir  = r_out_hasd;
    assign o_out_dir      = r_out_dir;
    assign o_out_x        = r_out_x;
    assign o_out_y        = r_out_y;
    assign o_out_last     = r_out_last;

    `MGSR_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(MAX_DIRS), "direction count above store depth")
    `MGSR_ASSERT_IMP(a_drain_idx, i_clk, i_rst_n, r_state == S_RD || r_state == S_OUT, r_rd_idx < r_count, "drain index past stored directions")
    `MGSR_ASSERT_NXT(a_pop_calc, i_clk, i_rst_n, o_q_pop, r_state == S_CALC, "popped transaction not taken into execution")
    `MGSR_ASSERT_NXT(a_emit_valid, i_clk, i_rst_n, w_emit, r_out_valid, "result load lost")

endmodule

`default_nettype wire

// ===== rtl/mouse_gesture_stroke_recognizer.sv =====
// channel   dir  handshake        payload
// s_axis    in   tvalid/tready    tdata pos_x,pos_y; tuser mode,alt_mode
// m_axis    out  tvalid/tready    tdata direction,origin_x,origin_y;
//                                 tuser consumed,has_direction; tlast last
// cfg       in   write enable     register index, write data
//
// each event passes through the execute states pop, delta, square and decide
// a matching finish with n directions then reads each direction from the store and emits it
// a two-entry queue lets the input side accept while a result waits on m_axis
// synchronous reset clears control state; the direction store is not cleared
// top level: config registers and port packing; depends on mgsr_pkg, mgsr_front,
// mgsr_fifo and mgsr_exec
`default_nettype none

module mouse_gesture_stroke_recognizer #(
    parameter int MAX_DIRS   = 16,
    parameter int COORD_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // pos_x, pos_y
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // mode, alt_mode
    input  wire logic [2:0]                        i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // direction, origin_x, origin_y
    output logic [((2*COORD_BITS+9)/8)*8-1:0]      o_m_axis_tdata,
    // consumed, has_direction
    output logic [1:0]                             o_m_axis_tuser,
    output logic                                   o_m_axis_tlast,
    input  wire logic                              i_cfg_we,
    input  wire logic [mgsr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [mgsr_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int IN_DATA_W  = ((2*COORD_BITS+7)/8)*8;
    localparam int OUT_DATA_W = ((2*COORD_BITS+9)/8)*8;
    localparam int ITEM_W     = $bits(mgsr_pkg::t_op) + 2*COORD_BITS;

    logic [7:0]        r_cfg_thr;
    logic [7:0]        r_cfg_tol;
    logic              r_cfg_plain;
    logic              r_cfg_alt;
    logic [15:0]       r_tol_sq;
    mgsr_pkg::t_cfg    w_cfg;

    logic              w_q_full, w_q_empty, w_push, w_pop;
    logic [ITEM_W-1:0] w_push_data, w_q_head;

    logic                  w_out_cons, w_out_hasd;
    logic [1:0]            w_out_dir;
    logic [COORD_BITS-1:0] w_out_x, w_out_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_thr   <= mgsr_pkg::CFG_RST_THRESHOLD;
            r_cfg_tol   <= mgsr_pkg::CFG_RST_TOL;
            r_cfg_plain <= 1'b1;
            r_cfg_alt   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mgsr_pkg::CFG_MOVE_THRESHOLD: r_cfg_thr   <= i_cfg_wdata;
                mgsr_pkg::CFG_STROKE_TOL:     r_cfg_tol   <= i_cfg_wdata;
                mgsr_pkg::CFG_PLAIN_EN:       r_cfg_plain <= i_cfg_wdata[0];
                mgsr_pkg::CFG_ALT_EN:         r_cfg_alt   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // squared tolerance, registered in the cycle after the tolerance register is written
    always_ff @(posedge i_clk) begin
        r_tol_sq <= r_cfg_tol * r_cfg_tol;
    end

    always_comb begin
        w_cfg.move_threshold = r_cfg_thr;
        w_cfg.tol_sq         = r_tol_sq;
        w_cfg.plain_en       = r_cfg_plain;
        w_cfg.alt_en         = r_cfg_alt;
    end

    mgsr_front #(
        .COORD_BITS (COORD_BITS),
        .IN_DATA_W  (IN_DATA_W),
        .ITEM_W     (ITEM_W)
    ) u_front (
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_cfg           (w_cfg),
        .i_q_full        (w_q_full),
        .o_push          (w_push),
        .o_push_data     (w_push_data)
    );

    mgsr_fifo #(
        .ITEM_W (ITEM_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_full      (w_q_full),
        .o_empty     (w_q_empty),
        .o_head      (w_q_head)
    );

    mgsr_exec #(
        .MAX_DIRS   (MAX_DIRS),
        .COORD_BITS (COORD_BITS),
        .ITEM_W     (ITEM_W)
    ) u_exec (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_q_empty      (w_q_empty),
        .i_q_head       (w_q_head),
        .o_q_pop        (w_pop),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_out_consumed (w_out_cons),
        .o_out_has_dir  (w_out_hasd),
        .o_out_dir      (w_out_dir),
        .o_out_x        (w_out_x),
        .o_out_y        (w_out_y),
        .o_out_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = OUT_DATA_W'({w_out_y, w_out_x, w_out_dir});
    assign o_m_axis_tuser = {w_out_hasd, w_out_cons};

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for mouse_gesture_stroke_recognizer: a directed script, then random gestures
// under several register settings, each result transaction checked against a gesture predictor
// depends on mgsr_pkg and the rtl top level
module tb_top;

    localparam int STORE_DEPTH = 16;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] x;
        logic [15:0] y;
        logic        alt;
    } t_ptr_event;

    typedef struct packed {
        logic        consumed;
        logic        has_dir;
        logic [1:0]  dir;
        logic [15:0] ox;
        logic [15:0] oy;
        logic        last;
    } t_stroke_res;

    typedef struct {
        logic [1:0] mode;
        int         x;
        int         y;
        bit         alt;
        bit         typed;
        bit         cons;
        int         ox;
        int         oy;
    } t_script_row;

    logic                            i_clk           = 1'b0;
    logic                            i_rst_n         = 1'b0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    // pos_x, pos_y
    logic [31:0]                     i_s_axis_tdata  = '0;
    // mode, alt_mode
    logic [2:0]                      i_s_axis_tuser  = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    // direction, origin_x, origin_y
    logic [39:0]                     o_m_axis_tdata;
    // consumed, has_direction
    logic [1:0]                      o_m_axis_tuser;
    logic                            o_m_axis_tlast;
    logic                            i_cfg_we        = 1'b0;
    logic [mgsr_pkg::CFG_IDX_W-1:0]  i_cfg_idx       = '0;
    logic [mgsr_pkg::CFG_DATA_W-1:0] i_cfg_wdata     = '0;

    // predictor state
    int          cfg_thr   = int'(mgsr_pkg::CFG_RST_THRESHOLD);
    int          cfg_tol   = int'(mgsr_pkg::CFG_RST_TOL);
    bit          en_plain  = 1'b1;
    bit          en_alt    = 1'b1;
    bit          g_active  = 1'b0;
    bit          g_rec     = 1'b0;
    bit          g_alt     = 1'b0;
    logic [15:0] ref_x     = '0;
    logic [15:0] ref_y     = '0;
    logic [15:0] org_x     = '0;
    logic [15:0] org_y     = '0;
    logic [2:0]  last_sec  = mgsr_pkg::SECTOR_NONE;
    logic [1:0]  dir_list [STORE_DEPTH];
    int          n_dirs    = 0;
    t_stroke_res burst [STORE_DEPTH];

    t_stroke_res pending_strokes [$];
    int          mismatch_count = 0;
    int          sent_events    = 0;
    int          src_idle       = 9;
    int          snk_idle       = 57;
    bit          sink_hold      = 1'b0;

    t_script_row script [26] = '{
        '{mgsr_pkg::MODE_MOVE,        0,      0, 1'b0, 1'b1, 1'b0,      0,      0},
        '{mgsr_pkg::MODE_FINISH,      0,      0, 1'b0, 1'b1, 1'b0,      0,      0},
        '{mgsr_pkg::MODE_START,     100,    100, 1'b0, 1'b1, 1'b0,    100,    100},
        '{mgsr_pkg::MODE_START,  -32768,  32767, 1'b1, 1'b1, 1'b0,    100,    100},
        '{mgsr_pkg::MODE_MOVE,      102,    101, 1'b0, 1'b1, 1'b0,    100,    100},
        '{mgsr_pkg::MODE_MOVE,      110,    100, 1'b0, 1'b1, 1'b1,    100,    100},
        '{mgsr_pkg::MODE_MOVE,      111,    100, 1'b0, 1'b1, 1'b1,    100,    100},
        '{mgsr_pkg::MODE_MOVE,      122,    100, 1'b0, 1'b1, 1'b1,    100,    100},
        '{mgsr_pkg::MODE_MOVE,      133,    100, 1'b0, 1'b1, 1'b1,    100,    100},
        '{mgsr_pkg::MODE_MOVE,      133,    200, 1'b0, 1'b1, 1'b1,    100,    100},
        '{mgsr_pkg::MODE_MOVE,      133,    300, 1'b0, 1'b1, 1'b1,    100,    100},
        '{mgsr_pkg::MODE_MOVE,       33,    300, 1'b0, 1'b1, 1'b1,    100,    100},
        '{mgsr_pkg::MODE_MOVE,      -67,    300, 1'b0, 1'b1, 1'b1,    100,    100},
        '{mgsr_pkg::MODE_MOVE,      -67,    200, 1'b0, 1'b1, 1'b1,    100,    100},
        '{mgsr_pkg::MODE_MOVE,      -67,    100, 1'b0, 1'b1, 1'b1,    100,    100},
        '{mgsr_pkg::MODE_FINISH,      0,      0, 1'b1, 1'b1, 1'b0,    100,    100},
        '{mgsr_pkg::MODE_FINISH,      0,      0, 1'b0, 1'b0, 1'b0,      0,      0},
        '{mgsr_pkg::MODE_START,  -32768, -32768, 1'b1, 1'b1, 1'b0, -32768, -32768},
        '{mgsr_pkg::MODE_MOVE,    32767,  32767, 1'b1, 1'b1, 1'b1, -32768, -32768},
        '{mgsr_pkg::MODE_MOVE,   -32768,  32767, 1'b1, 1'b1, 1'b1, -32768, -32768},
        '{mgsr_pkg::MODE_MOVE,        0,      0, 1'b0, 1'b1, 1'b0, -32768, -32768},
        '{mgsr_pkg::MODE_START,       0,      0, 1'b0, 1'b1, 1'b0,      0,      0},
        '{mgsr_pkg::MODE_FINISH,      0,      0, 1'b0, 1'b1, 1'b0,      0,      0},
        '{mgsr_pkg::MODE_START,       5,      5, 1'b0, 1'b1, 1'b0,      5,      5},
        '{mgsr_pkg::MODE_MOVE,        5,      0, 1'b0, 1'b1, 1'b1,      5,      5},
        '{mgsr_pkg::MODE_CANCEL,      5,      5, 1'b0, 1'b1, 1'b0,      5,      5}
    };

    mouse_gesture_stroke_recognizer DUT (.*);

    always #6 i_clk = ~i_clk;

    // gesture predictor: updates state, fills burst, returns the result count
    function automatic int step_gesture(input t_ptr_event ev);
        int         dx;
        int         dy;
        int         ax;
        int         ay;
        int         n;
        logic [1:0] sec;
        bit         took;
        bit         listed;
        n      = 1;
        took   = 1'b0;
        listed = 1'b0;
        case (ev.mode)
            mgsr_pkg::MODE_START: begin
                if (!g_active && (ev.alt ? en_alt : en_plain)) begin
                    g_active = 1'b1;
                    g_rec    = 1'b0;
                    g_alt    = ev.alt;
                    ref_x    = ev.x;
                    ref_y    = ev.y;
                    org_x    = ev.x;
                    org_y    = ev.y;
                    last_sec = mgsr_pkg::SECTOR_NONE;
                    n_dirs   = 0;
                end
            end
            mgsr_pkg::MODE_MOVE: begin
                if (g_active && ev.alt != g_alt) begin
                    g_active = 1'b0;
                end else if (g_active) begin
                    dx = int'($signed(ev.x)) - int'($signed(ref_x));
                    dy = int'($signed(ev.y)) - int'($signed(ref_y));
                    ax = (dx < 0) ? -dx : dx;
                    ay = (dy < 0) ? -dy : dy;
                    if (g_rec || ax >= cfg_thr || ay >= cfg_thr) begin
                        g_rec = 1'b1;
                        took  = 1'b1;
                        if (ax >= 256 || ay >= 256
                                || 4 * (ax * ax + ay * ay) > cfg_tol * cfg_tol) begin
                            ref_x = ev.x;
                            ref_y = ev.y;
                            if (ax >= ay)
                                sec = (dx >= 0) ? mgsr_pkg::DIR_RIGHT : mgsr_pkg::DIR_LEFT;
                            else
                                sec = (dy >= 0) ? mgsr_pkg::DIR_DOWN : mgsr_pkg::DIR_UP;
                            if (last_sec != {1'b0, sec}) begin
                                last_sec = {1'b0, sec};
                            end else if (n_dirs == 0 || dir_list[n_dirs-1] != sec) begin
                                if (n_dirs < STORE_DEPTH) begin
                                    dir_list[n_dirs] = sec;
                                    n_dirs++;
                                end
                            end
                        end
                    end
                end
            end
            mgsr_pkg::MODE_FINISH: begin
                if (g_active && ev.alt == g_alt) begin
                    g_active = 1'b0;
                    if (n_dirs > 0) begin
                        listed = 1'b1;
                        n      = n_dirs;
                        for (int i = 0; i < n_dirs; i++)
                            burst[i] = '{1'b1, 1'b1, dir_list[i], org_x, org_y,
                                         i == n_dirs - 1};
                    end
                end
            end
            default: g_active = 1'b0;
        endcase
        if (!listed) burst[0] = '{took, 1'b0, 2'b00, org_x, org_y, 1'b1};
        return n;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("tb_top: mismatch %s got %0h want %0h", what, got, want);
        mismatch_count++;
    endtask

    task automatic send_event(input t_ptr_event ev, input bit typed,
                              input t_stroke_res typed_res);
        int n;
        if (sent_events < 100) begin
            src_idle = 9;
            snk_idle = 57;
        end else if (sent_events < 200) begin
            src_idle = 57;
            snk_idle = 9;
        end else begin
            src_idle = 0;
            snk_idle = 0;
        end
        if ($urandom_range(0, 99) < src_idle) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {ev.y, ev.x};
        i_s_axis_tuser  <= {ev.alt, ev.mode};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sent_events++;
        n = step_gesture(ev);
        if (typed) pending_strokes = {pending_strokes, typed_res};
        else for (int i = 0; i < n; i++) pending_strokes = {pending_strokes, burst[i]};
    endtask

    task automatic offer(input logic [1:0] mode, input int x, input int y, input bit alt);
        t_ptr_event ev;
        ev = '{mode, x[15:0], y[15:0], alt};
        send_event(ev, 1'b0, '0);
    endtask

    task automatic offer_noise();
        offer(2'($urandom_range(0, 3)), $urandom, $urandom, 1'($urandom_range(0, 1)));
    endtask

    function automatic int clamp_coord(input int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    // start, strokes in a chain of headings with occasional noise events, then a finish or a cancel
    task automatic run_gesture();
        int         cx;
        int         cy;
        int         n_turns;
        int         step;
        int         side;
        int         pick;
        logic [1:0] heading;
        bit         alt;
        alt     = 1'($urandom_range(0, 1));
        cx      = $urandom_range(0, 16000) - 8000;
        cy      = $urandom_range(0, 16000) - 8000;
        offer(mgsr_pkg::MODE_START, cx, cy, alt);
        n_turns = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
        heading = 2'($urandom_range(0, 3));
        for (int t = 0; t < n_turns; t++) begin
            repeat ($urandom_range(2, 3)) begin
                if ($urandom_range(0, 24) == 0) offer_noise();
                case ($urandom_range(0, 3))
                    0:       step = $urandom_range(0, 20);
                    3:       step = $urandom_range(150, 600);
                    default: step = $urandom_range(20, 150);
                endcase
                side = $urandom_range(0, step / 2);
                if ($urandom_range(0, 1)) side = -side;
                case (heading)
                    mgsr_pkg::DIR_RIGHT: begin cx += step; cy += side; end
                    mgsr_pkg::DIR_DOWN:  begin cy += step; cx += side; end
                    mgsr_pkg::DIR_LEFT:  begin cx -= step; cy += side; end
                    default:             begin cy -= step; cx += side; end
                endcase
                cx = clamp_coord(cx);
                cy = clamp_coord(cy);
                offer(mgsr_pkg::MODE_MOVE, cx, cy, alt);
            end
            heading = heading + 2'($urandom_range(1, 3));
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            offer(mgsr_pkg::MODE_CANCEL, cx, cy, alt);
        end else begin
            if (pick == 1) offer(mgsr_pkg::MODE_FINISH, cx, cy, !alt);
            offer(mgsr_pkg::MODE_FINISH, cx, cy, alt);
        end
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (pending_strokes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mgsr_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            mgsr_pkg::CFG_MOVE_THRESHOLD: cfg_thr  = int'(val);
            mgsr_pkg::CFG_STROKE_TOL:     cfg_tol  = int'(val);
            mgsr_pkg::CFG_PLAIN_EN:       en_plain = val[0];
            mgsr_pkg::CFG_ALT_EN:         en_alt   = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int thr, input int tol, input bit pe, input bit ae);
        drain();
        write_reg(mgsr_pkg::CFG_MOVE_THRESHOLD, thr[7:0]);
        write_reg(mgsr_pkg::CFG_STROKE_TOL, tol[7:0]);
        write_reg(mgsr_pkg::CFG_PLAIN_EN, {7'd0, pe});
        write_reg(mgsr_pkg::CFG_ALT_EN, {7'd0, ae});
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (sink_hold) i_m_axis_tready <= 1'b0;
        else           i_m_axis_tready <= ($urandom_range(0, 99) >= snk_idle);
    end

    always @(posedge i_clk) begin : watch_results
        t_stroke_res seen;
        t_stroke_res want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen = '{o_m_axis_tuser[0], o_m_axis_tuser[1], o_m_axis_tdata[1:0],
                     o_m_axis_tdata[17:2], o_m_axis_tdata[33:18], o_m_axis_tlast};
            if (pending_strokes.size() == 0) begin
                report_mismatch("transaction with nothing expected", o_m_axis_tdata, 0);
            end else begin
                want = pending_strokes.pop_front();
                if (seen.consumed !== want.consumed)
                    report_mismatch("consumed", seen.consumed, want.consumed);
                if (seen.has_dir !== want.has_dir)
                    report_mismatch("has_direction", seen.has_dir, want.has_dir);
                if (seen.dir !== want.dir)
                    report_mismatch("direction", seen.dir, want.dir);
                if (seen.ox !== want.ox)
                    report_mismatch("origin_x", seen.ox, want.ox);
                if (seen.oy !== want.oy)
                    report_mismatch("origin_y", seen.oy, want.oy);
                if (seen.last !== want.last)
                    report_mismatch("last", seen.last, want.last);
            end
        end
    end

    // long receiver hold-off so the input side backs up
    initial begin
        wait (sent_events >= 150);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        t_ptr_event  ev;
        t_stroke_res want;
        int          stop_at;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (script[k]) begin
            ev   = '{script[k].mode, script[k].x[15:0], script[k].y[15:0], script[k].alt};
            want = '{script[k].cons, 1'b0, 2'b00, script[k].ox[15:0], script[k].oy[15:0], 1'b1};
            send_event(ev, script[k].typed, want);
        end
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config(0, 0, 1'b1, 1'b1);
                1: set_config(255, 255, 1'b0, 1'b1);
                2: set_config(3, 30, 1'b1, 1'b0);
                3: set_config($urandom_range(0, 255), $urandom_range(0, 255), 1'b1, 1'b1);
                4: set_config($urandom_range(0, 40), $urandom_range(0, 60),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                default: set_config(5, 20, 1'b1, 1'b1);
            endcase
            stop_at = sent_events + 38;
            while (sent_events < stop_at) begin
                if ($urandom_range(0, 6) == 0) repeat ($urandom_range(1, 4)) offer_noise();
                else run_gesture();
            end
        end
        drain();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) $display("tb_top: done, clean");
        else $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mgsr_pkg.sv
rtl/mgsr_front.sv
rtl/mgsr_fifo.sv
rtl/mgsr_exec.sv
rtl/mouse_gesture_stroke_recognizer.sv
bench/tb_top.sv
